// ----- design/lz77pc_pkg.sv -----
// ----------------------------------------------------------------------------
// lz77pc_pkg
// Shared types and codes for the pair-chain match finder: command codes,
// datapath operation codes, read-address selects and control/status structs.
// ----------------------------------------------------------------------------
package lz77pc_pkg;

    // Command codes carried by one input beat
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_ADD   = 2'd2;
    localparam t_cmd CMD_FIND  = 2'd3;

    // Length limits
    localparam logic [15:0] MIN_MATCH = 16'd3;
    localparam logic [15:0] MIN_PAIR  = 16'd2;

    // Pair table geometry: one entry per two-byte key
    localparam int          HEAD_DEPTH = 65536;
    localparam logic [15:0] HEAD_LAST  = 16'hFFFF;

    // Datapath operations, one per cycle
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_POSM      = 5'd2;
    localparam t_op OP_CLR_STEP  = 5'd3;
    localparam t_op OP_WRITE     = 5'd4;
    localparam t_op OP_CAP_X     = 5'd5;
    localparam t_op OP_CAP_Y     = 5'd6;
    localparam t_op OP_CAP_Z     = 5'd7;
    localparam t_op OP_CAP_M1    = 5'd8;
    localparam t_op OP_CAP_M2    = 5'd9;
    localparam t_op OP_ADD       = 5'd10;
    localparam t_op OP_CAP_HEAD  = 5'd11;
    localparam t_op OP_REP_INIT  = 5'd12;
    localparam t_op OP_REP_INC   = 5'd13;
    localparam t_op OP_CAP_CANDM = 5'd14;
    localparam t_op OP_SKIP_STEP = 5'd15;
    localparam t_op OP_NEXT      = 5'd16;
    localparam t_op OP_CMP_INIT  = 5'd17;
    localparam t_op OP_CAP_A     = 5'd18;
    localparam t_op OP_CMP_INC   = 5'd19;
    localparam t_op OP_BEST      = 5'd20;
    localparam t_op OP_FIN       = 5'd21;

    // Chunk read address selects
    typedef logic [2:0] t_rsel;
    localparam t_rsel RS_POS  = 3'd0;
    localparam t_rsel RS_POS1 = 3'd1;
    localparam t_rsel RS_POS2 = 3'd2;
    localparam t_rsel RS_PM1  = 3'd3;
    localparam t_rsel RS_PM2  = 3'd4;
    localparam t_rsel RS_PA   = 3'd5;
    localparam t_rsel RS_C2   = 3'd6;
    localparam t_rsel RS_S    = 3'd7;

    // Controller to datapath
    typedef struct packed {
        t_op   op;
        t_rsel rsel;
        logic  mod_cur;     // reduce the chain entry instead of the position
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic gate_fail;
        logic add_ok;
        logic cur_valid;
        logic rep_hit;
        logic rep_one;
        logic two_back;
        logic len_lt_max;
        logic len_eq_max;
        logic rep_eq;
        logic skip_nz;
        logic visits_ok;
        logic cand_lt_win;
        logic cand_lt_pos;
        logic z_eq;
        logic i_lt_max;
        logic i_eq_max;
        logic i_gt_len;
        logic cmp_eq;
        logic clr_last;
    } t_sts;

endpackage

// ----- design/lz77pc_dp.sv -----
// ----------------------------------------------------------------------------
// lz77pc_dp
// Datapath: chunk, pair-head and chain-link memories, the modulo reducer for
// chunk addresses, and the working registers of the match search.
// ----------------------------------------------------------------------------
module lz77pc_dp #(
    parameter int CHUNK_SIZE = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lz77pc_pkg::t_ctl    i_ctl,
    output lz77pc_pkg::t_sts    o_sts,
    input  logic [15:0]         i_position,
    input  logic [7:0]          i_byte_value,
    input  logic [15:0]         i_max_length,
    input  logic [15:0]         i_window_start,
    output logic [15:0]         o_match_length,
    output logic [15:0]         o_match_offset
);

    localparam int             AW    = $clog2(CHUNK_SIZE);
    localparam logic [AW-1:0]  LAST  = AW'(CHUNK_SIZE - 1);
    localparam logic [AW:0]    CW    = (AW+1)'(CHUNK_SIZE);
    localparam int             MULT  = 16777216 / CHUNK_SIZE;
    localparam int             PW    = 33;
    localparam int             QW    = 26;

    // Wrap helpers for addresses already below CHUNK_SIZE
    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        inc_wrap = (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                               input logic [1:0]    k);
        logic [AW:0] sum;
        sum = {1'b0, a} + (AW+1)'(k);
        add_wrap = (sum >= CW) ? AW'(sum - CW) : sum[AW-1:0];
    endfunction

    // Memories
    logic [7:0]  r_chunk_mem [CHUNK_SIZE];
    logic [16:0] r_head_mem  [lz77pc_pkg::HEAD_DEPTH];
    logic [16:0] r_link_mem  [CHUNK_SIZE];

    // Working registers
    logic [15:0]   r_pos, r_maxl, r_win;
    logic [7:0]    r_val;
    logic [AW-1:0] r_pos_m, r_cand_m, r_pa, r_s_m;
    logic [7:0]    r_x, r_y, r_z, r_m1, r_m2, r_a;
    logic [16:0]   r_cur;
    logic [15:0]   r_len, r_off, r_i;
    logic [16:0]   r_s;
    logic [1:0]    r_skip;
    logic [AW:0]   r_visits;
    logic [15:0]   r_clr;
    logic [7:0]    r_byte;
    logic [16:0]   r_head_q, r_link_q;
    logic [15:0]   r_out_len, r_out_off;

    // Modulo reducer registers
    logic [15:0]   r_mod_src;
    logic [PW-1:0] r_prod;
    logic [AW:0]   r_rem;

    logic [15:0]   mod_in;
    logic [QW-1:0] mod_diff;
    logic [AW-1:0] mod_res;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rep_exp;
    logic [15:0]   cand;
    logic [16:0]   s_init, s_nxt;
    logic [15:0]   len_gate;

    assign cand = r_cur[15:0];

    // Reduce a position modulo CHUNK_SIZE by reciprocal multiply and one fix
    assign mod_in   = i_ctl.mod_cur ? cand : r_pos;
    assign mod_diff = QW'(r_mod_src) - QW'(r_prod[PW-1:24]) * QW'(CHUNK_SIZE);
    assign mod_res  = (r_rem >= CW) ? AW'(r_rem - CW) : r_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_mod_src <= mod_in;
        r_prod    <= PW'(mod_in) * PW'(MULT);
        r_rem     <= mod_diff[AW:0];
    end

    // Select the chunk read address
    always_comb begin
        unique case (i_ctl.rsel)
            lz77pc_pkg::RS_POS:  rd_addr = r_pos_m;
            lz77pc_pkg::RS_POS1: rd_addr = add_wrap(r_pos_m, 2'd1);
            lz77pc_pkg::RS_POS2: rd_addr = add_wrap(r_pos_m, 2'd2);
            lz77pc_pkg::RS_PM1:  rd_addr = (r_pos_m == '0) ? LAST : r_pos_m - 1'b1;
            lz77pc_pkg::RS_PM2:  rd_addr = (r_pos_m < AW'(2)) ?
                                           AW'({1'b0, r_pos_m} + CW - (AW+1)'(2)) :
                                           r_pos_m - AW'(2);
            lz77pc_pkg::RS_PA:   rd_addr = r_pa;
            lz77pc_pkg::RS_C2:   rd_addr = add_wrap(r_cand_m, 2'd2);
            lz77pc_pkg::RS_S:    rd_addr = r_s_m;
            default:             rd_addr = r_pos_m;
        endcase
    end

    // Chunk store
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == lz77pc_pkg::OP_WRITE) begin
            r_chunk_mem[r_pos_m] <= r_val;
        end
        r_byte <= r_chunk_mem[rd_addr];
    end

    // Pair heads: cleared by sweep, written on add
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == lz77pc_pkg::OP_CLR_STEP) begin
            r_head_mem[r_clr] <= '0;
        end else if (i_ctl.op == lz77pc_pkg::OP_ADD) begin
            r_head_mem[{r_x, r_y}] <= {1'b1, r_pos};
        end
        r_head_q <= r_head_mem[{r_x, r_y}];
    end

    // Chain links
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == lz77pc_pkg::OP_ADD) begin
            r_link_mem[r_pos_m] <= r_head_q;
        end
        r_link_q <= r_link_mem[r_cand_m];
    end

    // Clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.op == lz77pc_pkg::OP_LOAD) begin
            r_clr <= '0;
        end else if (i_ctl.op == lz77pc_pkg::OP_CLR_STEP) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign rep_exp  = (r_off == 16'd1) ? r_x : (r_len[0] ? r_y : r_x);
    assign s_init   = ({1'b0, cand} + 17'd3 == {1'b0, r_pos}) ? {1'b0, cand}
                                                             : {1'b0, cand} + 17'd3;
    assign s_nxt    = r_s + 1'b1;
    assign len_gate = (r_len >= lz77pc_pkg::MIN_MATCH) ? r_len : '0;

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            lz77pc_pkg::OP_LOAD: begin
                r_pos    <= i_position;
                r_val    <= i_byte_value;
                r_maxl   <= i_max_length;
                r_win    <= i_window_start;
                r_len    <= '0;
                r_off    <= '0;
                r_skip   <= '0;
                r_visits <= '0;
            end
            lz77pc_pkg::OP_POSM:      r_pos_m <= mod_res;
            lz77pc_pkg::OP_CAP_X:     r_x     <= r_byte;
            lz77pc_pkg::OP_CAP_Y:     r_y     <= r_byte;
            lz77pc_pkg::OP_CAP_Z:     r_z     <= r_byte;
            lz77pc_pkg::OP_CAP_M1:    r_m1    <= r_byte;
            lz77pc_pkg::OP_CAP_M2:    r_m2    <= r_byte;
            lz77pc_pkg::OP_CAP_HEAD:  r_cur   <= r_head_q;
            lz77pc_pkg::OP_REP_INIT: begin
                r_len <= lz77pc_pkg::MIN_MATCH;
                r_pa  <= add_wrap(r_pos_m, 2'd3);
                if (o_sts.rep_one) begin
                    r_off  <= 16'd1;
                    r_skip <= o_sts.two_back ? 2'd2 : 2'd1;
                end else begin
                    r_off  <= 16'd2;
                    r_skip <= 2'd1;
                end
            end
            lz77pc_pkg::OP_REP_INC: begin
                r_len <= r_len + 1'b1;
                r_pa  <= inc_wrap(r_pa);
            end
            lz77pc_pkg::OP_CAP_CANDM: r_cand_m <= mod_res;
            lz77pc_pkg::OP_SKIP_STEP: begin
                r_cur  <= r_link_q;
                r_skip <= r_skip - 1'b1;
            end
            lz77pc_pkg::OP_NEXT: begin
                r_cur    <= r_link_q;
                r_visits <= r_visits + 1'b1;
            end
            lz77pc_pkg::OP_CMP_INIT: begin
                r_i   <= lz77pc_pkg::MIN_MATCH;
                r_pa  <= add_wrap(r_pos_m, 2'd3);
                r_s   <= s_init;
                r_s_m <= (s_init[15:0] == cand) ? r_cand_m : add_wrap(r_cand_m, 2'd3);
            end
            lz77pc_pkg::OP_CAP_A:     r_a <= r_byte;
            lz77pc_pkg::OP_CMP_INC: begin
                r_i  <= r_i + 1'b1;
                r_pa <= inc_wrap(r_pa);
                if (s_nxt == {1'b0, r_pos}) begin
                    r_s   <= {1'b0, cand};
                    r_s_m <= r_cand_m;
                end else begin
                    r_s   <= s_nxt;
                    r_s_m <= inc_wrap(r_s_m);
                end
            end
            lz77pc_pkg::OP_BEST: begin
                if (r_i > r_len) begin
                    r_len <= r_i;
                    r_off <= r_pos - cand;
                end
            end
            lz77pc_pkg::OP_FIN: begin
                r_out_len <= len_gate;
                r_out_off <= (r_len >= lz77pc_pkg::MIN_MATCH) ? r_off : '0;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller
    always_comb begin
        o_sts.gate_fail   = (r_maxl < lz77pc_pkg::MIN_MATCH) || (r_pos <= r_win);
        o_sts.add_ok      = (r_maxl >= lz77pc_pkg::MIN_PAIR);
        o_sts.cur_valid   = r_cur[16];
        o_sts.rep_hit     = (r_x == r_z) && (r_y == r_m1);
        o_sts.rep_one     = (r_x == r_y);
        o_sts.two_back    = ((r_pos - r_win) > 16'd1) && (r_x == r_m2);
        o_sts.len_lt_max  = (r_len < r_maxl);
        o_sts.len_eq_max  = (r_len == r_maxl);
        o_sts.rep_eq      = (r_byte == rep_exp);
        o_sts.skip_nz     = (r_skip != '0);
        o_sts.visits_ok   = (r_visits < CW);
        o_sts.cand_lt_win = (cand < r_win);
        o_sts.cand_lt_pos = (cand < r_pos);
        o_sts.z_eq        = (r_byte == r_z);
        o_sts.i_lt_max    = (r_i < r_maxl);
        o_sts.i_eq_max    = (r_i == r_maxl);
        o_sts.i_gt_len    = (r_i > r_len);
        o_sts.cmp_eq      = (r_byte == r_a);
        o_sts.clr_last    = (r_clr == lz77pc_pkg::HEAD_LAST);
    end

    assign o_match_length = r_out_len;
    assign o_match_offset = r_out_off;

endmodule

// ----- design/lz77pc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lz77pc_ctrl
// Controller: sequences clear sweeps, byte writes, chain inserts and the
// match search by issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module lz77pc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_command,
    input  lz77pc_pkg::t_sts  i_sts,
    output lz77pc_pkg::t_ctl  o_ctl,
    output logic              busy,
    output logic              o_valid
);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_CLR     = 6'd1;
    localparam logic [5:0] ST_P_M1    = 6'd2;
    localparam logic [5:0] ST_P_M2    = 6'd3;
    localparam logic [5:0] ST_P_CAP   = 6'd4;
    localparam logic [5:0] ST_DISP    = 6'd5;
    localparam logic [5:0] ST_WR      = 6'd6;
    localparam logic [5:0] ST_A_X     = 6'd7;
    localparam logic [5:0] ST_A_Y     = 6'd8;
    localparam logic [5:0] ST_A_CY    = 6'd9;
    localparam logic [5:0] ST_A_W     = 6'd10;
    localparam logic [5:0] ST_A_ADD   = 6'd11;
    localparam logic [5:0] ST_F_X     = 6'd12;
    localparam logic [5:0] ST_F_Y     = 6'd13;
    localparam logic [5:0] ST_F_Z     = 6'd14;
    localparam logic [5:0] ST_F_M1    = 6'd15;
    localparam logic [5:0] ST_F_M2    = 6'd16;
    localparam logic [5:0] ST_F_CM2   = 6'd17;
    localparam logic [5:0] ST_F_H     = 6'd18;
    localparam logic [5:0] ST_F_DEC   = 6'd19;
    localparam logic [5:0] ST_REP_CHK = 6'd20;
    localparam logic [5:0] ST_REP_CMP = 6'd21;
    localparam logic [5:0] ST_REP_END = 6'd22;
    localparam logic [5:0] ST_SKIP    = 6'd23;
    localparam logic [5:0] ST_SK_M1   = 6'd24;
    localparam logic [5:0] ST_SK_M2   = 6'd25;
    localparam logic [5:0] ST_SK_CAP  = 6'd26;
    localparam logic [5:0] ST_SK_W    = 6'd27;
    localparam logic [5:0] ST_SK_STEP = 6'd28;
    localparam logic [5:0] ST_WALK    = 6'd29;
    localparam logic [5:0] ST_W_M1    = 6'd30;
    localparam logic [5:0] ST_W_M2    = 6'd31;
    localparam logic [5:0] ST_W_CAP   = 6'd32;
    localparam logic [5:0] ST_W_RZ    = 6'd33;
    localparam logic [5:0] ST_W_Z     = 6'd34;
    localparam logic [5:0] ST_CMP_CHK = 6'd35;
    localparam logic [5:0] ST_CMP_A   = 6'd36;
    localparam logic [5:0] ST_CMP_B   = 6'd37;
    localparam logic [5:0] ST_CMP_END = 6'd38;
    localparam logic [5:0] ST_NEXT_W  = 6'd39;
    localparam logic [5:0] ST_NEXT    = 6'd40;
    localparam logic [5:0] ST_FIN     = 6'd41;

    logic [5:0] r_state, n_state;
    logic [1:0] r_cmd;
    logic       r_valid;

    // Next state and datapath command
    always_comb begin
        n_state       = r_state;
        o_ctl.op      = lz77pc_pkg::OP_NOP;
        o_ctl.rsel    = lz77pc_pkg::RS_POS;
        o_ctl.mod_cur = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctl.op = lz77pc_pkg::OP_LOAD;
                    n_state  = ST_P_M1;
                end
            end
            ST_CLR: begin
                o_ctl.op = lz77pc_pkg::OP_CLR_STEP;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_P_M1: n_state = ST_P_M2;
            ST_P_M2: n_state = ST_P_CAP;
            ST_P_CAP: begin
                o_ctl.op = lz77pc_pkg::OP_POSM;
                n_state  = ST_DISP;
            end
            ST_DISP: begin
                case (r_cmd)
                    lz77pc_pkg::CMD_CLEAR: n_state = ST_CLR;
                    lz77pc_pkg::CMD_WRITE: n_state = ST_WR;
                    lz77pc_pkg::CMD_ADD:   n_state = i_sts.add_ok ? ST_A_X : ST_IDLE;
                    default:               n_state = i_sts.gate_fail ? ST_FIN : ST_F_X;
                endcase
            end
            ST_WR: begin
                o_ctl.op = lz77pc_pkg::OP_WRITE;
                n_state  = ST_IDLE;
            end
            // Insert: read the pair, then link the old head behind the new one
            ST_A_X: n_state = ST_A_Y;
            ST_A_Y: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_X;
                o_ctl.rsel = lz77pc_pkg::RS_POS1;
                n_state    = ST_A_CY;
            end
            ST_A_CY: begin
                o_ctl.op = lz77pc_pkg::OP_CAP_Y;
                n_state  = ST_A_W;
            end
            ST_A_W: n_state = ST_A_ADD;
            ST_A_ADD: begin
                o_ctl.op = lz77pc_pkg::OP_ADD;
                n_state  = ST_IDLE;
            end
            // Find: fetch the bytes around the position and the chain head
            ST_F_X: n_state = ST_F_Y;
            ST_F_Y: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_X;
                o_ctl.rsel = lz77pc_pkg::RS_POS1;
                n_state    = ST_F_Z;
            end
            ST_F_Z: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_Y;
                o_ctl.rsel = lz77pc_pkg::RS_POS2;
                n_state    = ST_F_M1;
            end
            ST_F_M1: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_Z;
                o_ctl.rsel = lz77pc_pkg::RS_PM1;
                n_state    = ST_F_M2;
            end
            ST_F_M2: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_M1;
                o_ctl.rsel = lz77pc_pkg::RS_PM2;
                n_state    = ST_F_CM2;
            end
            ST_F_CM2: begin
                o_ctl.op = lz77pc_pkg::OP_CAP_M2;
                n_state  = ST_F_H;
            end
            ST_F_H: begin
                o_ctl.op = lz77pc_pkg::OP_CAP_HEAD;
                n_state  = ST_F_DEC;
            end
            ST_F_DEC: begin
                if (!i_sts.cur_valid) begin
                    n_state = ST_FIN;
                end else if (i_sts.rep_hit && (i_sts.rep_one || i_sts.two_back)) begin
                    o_ctl.op = lz77pc_pkg::OP_REP_INIT;
                    n_state  = ST_REP_CHK;
                end else begin
                    n_state = ST_SKIP;
                end
            end
            // Extend the short repeat one byte at a time
            ST_REP_CHK: begin
                o_ctl.rsel = lz77pc_pkg::RS_PA;
                n_state    = i_sts.len_lt_max ? ST_REP_CMP : ST_REP_END;
            end
            ST_REP_CMP: begin
                if (i_sts.rep_eq) begin
                    o_ctl.op = lz77pc_pkg::OP_REP_INC;
                    n_state  = ST_REP_CHK;
                end else begin
                    n_state = ST_REP_END;
                end
            end
            ST_REP_END: n_state = i_sts.len_eq_max ? ST_FIN : ST_SKIP;
            // Drop the newest chain entries already covered by the repeat
            ST_SKIP: begin
                n_state = (i_sts.skip_nz && i_sts.cur_valid) ? ST_SK_M1 : ST_WALK;
            end
            ST_SK_M1: begin
                o_ctl.mod_cur = 1'b1;
                n_state       = ST_SK_M2;
            end
            ST_SK_M2: begin
                o_ctl.mod_cur = 1'b1;
                n_state       = ST_SK_CAP;
            end
            ST_SK_CAP: begin
                o_ctl.op = lz77pc_pkg::OP_CAP_CANDM;
                n_state  = ST_SK_W;
            end
            ST_SK_W: n_state = ST_SK_STEP;
            ST_SK_STEP: begin
                o_ctl.op = lz77pc_pkg::OP_SKIP_STEP;
                n_state  = ST_SKIP;
            end
            // Walk the chain from newest to oldest
            ST_WALK: begin
                if (!(i_sts.cur_valid && i_sts.visits_ok) || i_sts.cand_lt_win) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_W_M1;
                end
            end
            ST_W_M1: begin
                o_ctl.mod_cur = 1'b1;
                n_state       = ST_W_M2;
            end
            ST_W_M2: begin
                o_ctl.mod_cur = 1'b1;
                n_state       = ST_W_CAP;
            end
            ST_W_CAP: begin
                o_ctl.op = lz77pc_pkg::OP_CAP_CANDM;
                n_state  = ST_W_RZ;
            end
            ST_W_RZ: begin
                o_ctl.rsel = lz77pc_pkg::RS_C2;
                n_state    = i_sts.cand_lt_pos ? ST_W_Z : ST_NEXT_W;
            end
            ST_W_Z: begin
                if (i_sts.z_eq) begin
                    o_ctl.op = lz77pc_pkg::OP_CMP_INIT;
                    n_state  = ST_CMP_CHK;
                end else begin
                    n_state = ST_NEXT_W;
                end
            end
            // Compare the candidate against the position byte by byte
            ST_CMP_CHK: begin
                o_ctl.rsel = lz77pc_pkg::RS_PA;
                n_state    = i_sts.i_lt_max ? ST_CMP_A : ST_CMP_END;
            end
            ST_CMP_A: begin
                o_ctl.op   = lz77pc_pkg::OP_CAP_A;
                o_ctl.rsel = lz77pc_pkg::RS_S;
                n_state    = ST_CMP_B;
            end
            ST_CMP_B: begin
                if (i_sts.cmp_eq) begin
                    o_ctl.op = lz77pc_pkg::OP_CMP_INC;
                    n_state  = ST_CMP_CHK;
                end else begin
                    n_state = ST_CMP_END;
                end
            end
            ST_CMP_END: begin
                o_ctl.op = lz77pc_pkg::OP_BEST;
                n_state  = (i_sts.i_gt_len && i_sts.i_eq_max) ? ST_FIN : ST_NEXT_W;
            end
            ST_NEXT_W: n_state = ST_NEXT;
            ST_NEXT: begin
                o_ctl.op = lz77pc_pkg::OP_NEXT;
                n_state  = ST_WALK;
            end
            ST_FIN: begin
                o_ctl.op = lz77pc_pkg::OP_FIN;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State, latched command and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_cmd   <= lz77pc_pkg::CMD_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_FIN);
            if (r_state == ST_IDLE && start) begin
                r_cmd <= i_command;
            end
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_FIN))
        else $error("result strobe without a finished search");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_fin_only_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_cmd == lz77pc_pkg::CMD_FIND))
        else $error("result produced for a command other than find");

endmodule

// ----- design/lz77_pair_chain_match_finder_top.sv -----
// ----------------------------------------------------------------------------
// lz77_pair_chain_match_finder_top
// LZ77 match finder over a chunk buffer with pair-keyed hash chains.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       i_command, i_position, i_byte_value,
//                               i_max_length, i_window_start
//  result    o_valid (strobe)   o_match_length, o_match_offset
//
//  Clear sweeps one pair-table entry a cycle. A find that is gated, or whose
//  chain is empty, ends without a search; otherwise it extends a short repeat
//  where one is found, skips the chain entries that it covers, walks the chain
//  and compares candidate bytes in turn, all through the single chunk read
//  port and the two-stage address reducer.
//  After reset a sweep clears the pair table with busy high.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module lz77_pair_chain_match_finder_top #(
    parameter int CHUNK_SIZE = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_position,
    input  logic [7:0]  i_byte_value,
    input  logic [15:0] i_max_length,
    input  logic [15:0] i_window_start,
    output logic        o_valid,
    output logic [15:0] o_match_length,
    output logic [15:0] o_match_offset
);

    lz77pc_pkg::t_ctl ctl;
    lz77pc_pkg::t_sts sts;
    logic             accept;

    assign accept = start && !busy;

    lz77pc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (accept),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .busy      (busy),
        .o_valid   (o_valid)
    );

    lz77pc_dp #(
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_position     (i_position),
        .i_byte_value   (i_byte_value),
        .i_max_length   (i_max_length),
        .i_window_start (i_window_start),
        .o_match_length (o_match_length),
        .o_match_offset (o_match_offset)
    );

endmodule
